FILE: hw/rtl/tcmal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmal_pkg
// Shared constants and controller/datapath interface types for the
// three-channel moving average level block.
// ----------------------------------------------------------------------------
package tcmal_pkg;

    localparam int WINDOW       = 8;
    localparam int READING_BITS = 16;
    localparam int NUM_CHANNELS = 3;
    localparam int CHAN_BITS    = 2;
    localparam int POS_BITS     = $clog2(WINDOW);
    localparam int WIN_SHIFT    = $clog2(WINDOW);
    localparam int SUM_BITS     = READING_BITS + POS_BITS;
    localparam int FS_BITS      = 16;
    localparam int LEVEL_BITS   = 8;
    localparam int PROD_BITS    = READING_BITS + LEVEL_BITS;
    localparam int DIV_STEPS    = LEVEL_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [FS_BITS-1:0]    FULL_SCALE_RESET = FS_BITS'(6062);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX        = LEVEL_BITS'(255);

    localparam logic [CHAN_BITS-1:0] CH_RED    = 2'd0;
    localparam logic [CHAN_BITS-1:0] CH_GREEN  = 2'd1;
    localparam logic [CHAN_BITS-1:0] CH_BLUE   = 2'd2;
    localparam logic [CHAN_BITS-1:0] CH_UNUSED = 2'd3;

    typedef struct packed {
        logic capture;
        logic update;
        logic scale;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_chan_ok;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/three_channel_moving_average_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_moving_average_level
// Per-channel boxcar moving average of magnitude readings with a saturated
// 8-bit level scaled against a programmable full scale.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  input     in         i_valid / o_stall  i_channel, i_reading
//  output    out        o_valid / i_stall  o_out_channel, o_average, o_level
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// A request for channels 0 to 2 passes from acceptance through one capture,
// one ring update, one scaling step, eight steps of the restoring divider
// that forms the level, and one output load before the next acceptance.
// A request for channel 3 is taken and dropped without leaving idle.
// Reset clears the rings, sums and ring position at once; no clearing pass.
// A stalled result holds in the output register and delays only the load.
// ----------------------------------------------------------------------------
module three_channel_moving_average_level
    import tcmal_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHAN_BITS-1:0]    i_channel,
    input  logic [READING_BITS-1:0] i_reading,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CHAN_BITS-1:0]    o_out_channel,
    output logic [READING_BITS-1:0] o_average,
    output logic [LEVEL_BITS-1:0]   o_level,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [FS_BITS-1:0]      i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    tcmal_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    tcmal_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_channel     (i_channel),
        .i_reading     (i_reading),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_average     (o_average),
        .o_level       (o_level)
    );

    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_channel == CH_UNUSED)) |=> !o_stall)
        else $error("Channel 3 request did not leave the block ready.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_channel != CH_UNUSED)) |=> o_stall)
        else $error("Block took a request without going busy.");

    a_result_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_channel != CH_UNUSED))
        else $error("Result carries the unused channel code.");

    a_zero_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_average == '0)) |-> (o_level == '0))
        else $error("Zero average produced a nonzero level.");

endmodule

FILE: hw/rtl/tcmal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmal_ctrl
// Sequencer for the moving average block: accepts one request, steps the
// datapath through update, scaling and division, then loads the output.
// ----------------------------------------------------------------------------
module tcmal_ctrl
    import tcmal_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_SCALE  = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_count, n_count;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_valid;
                if (i_valid && i_status.in_chan_ok) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_count     = '0;
                n_state     = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_count        = r_count + 1'b1;
                if (r_count == STEP_BITS'(DIV_STEPS - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/tcmal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcmal_dp
// Datapath: full-scale registers, per-channel rings and running sums,
// a restoring divider for the level, and the output register.
// ----------------------------------------------------------------------------
module tcmal_dp
    import tcmal_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [CHAN_BITS-1:0]    i_channel,
    input  logic [READING_BITS-1:0] i_reading,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [FS_BITS-1:0]      i_cfg_data,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [CHAN_BITS-1:0]    o_out_channel,
    output logic [READING_BITS-1:0] o_average,
    output logic [LEVEL_BITS-1:0]   o_level
);

    logic [FS_BITS-1:0]      r_fs   [NUM_CHANNELS];
    logic [READING_BITS-1:0] r_ring [NUM_CHANNELS][WINDOW];
    logic [SUM_BITS-1:0]     r_sum  [NUM_CHANNELS];
    logic [POS_BITS-1:0]     r_pos;

    logic [CHAN_BITS-1:0]    r_ch;
    logic [READING_BITS-1:0] r_rd;
    logic [READING_BITS-1:0] r_avg;
    logic [FS_BITS-1:0]      r_rem;
    logic [LEVEL_BITS-1:0]   r_low;
    logic [LEVEL_BITS-1:0]   r_quo;
    logic                    r_sat;
    logic                    r_zero;

    logic                    r_o_valid;
    logic [CHAN_BITS-1:0]    r_o_ch;
    logic [READING_BITS-1:0] r_o_avg;
    logic [LEVEL_BITS-1:0]   r_o_level;

    logic [READING_BITS-1:0] w_old;
    logic [SUM_BITS-1:0]     n_sum;
    logic [FS_BITS-1:0]      w_fs;
    logic [PROD_BITS-1:0]    w_prod;
    logic [FS_BITS:0]        w_trial;
    logic                    w_fits;

    assign w_old   = r_ring[r_ch][r_pos];
    assign n_sum   = r_sum[r_ch] - SUM_BITS'(w_old) + SUM_BITS'(r_rd);
    assign w_fs    = r_fs[r_ch];
    assign w_prod  = {r_avg, LEVEL_BITS'(0)} - PROD_BITS'(r_avg);
    assign w_trial = {r_rem, r_low[LEVEL_BITS-1]};
    assign w_fits  = (w_trial >= {1'b0, w_fs});

    assign o_status.in_chan_ok = (i_channel != CH_UNUSED);
    assign o_status.out_free   = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_fs[c] <= FULL_SCALE_RESET;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_BITS'(NUM_CHANNELS))) begin
            r_fs[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_sum[c] <= '0;
                for (int p = 0; p < WINDOW; p++) begin
                    r_ring[c][p] <= '0;
                end
            end
            r_pos <= '0;
        end else if (i_cmd.update) begin
            r_sum[r_ch]         <= n_sum;
            r_ring[r_ch][r_pos] <= r_rd;
            if (r_ch == CH_BLUE) begin
                r_pos <= (r_pos == POS_BITS'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch <= i_channel;
            r_rd <= i_reading;
        end
        if (i_cmd.update) begin
            r_avg <= n_sum[SUM_BITS-1:WIN_SHIFT];
        end
        if (i_cmd.scale) begin
            r_rem  <= w_prod[PROD_BITS-1:LEVEL_BITS];
            r_low  <= w_prod[LEVEL_BITS-1:0];
            r_sat  <= (r_avg > w_fs);
            r_zero <= (w_fs == '0);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_fits ? FS_BITS'(w_trial - {1'b0, w_fs}) : w_trial[FS_BITS-1:0];
            r_quo <= {r_quo[LEVEL_BITS-2:0], w_fits};
            r_low <= {r_low[LEVEL_BITS-2:0], 1'b0};
        end
        if (i_cmd.load_out) begin
            r_o_ch    <= r_ch;
            r_o_avg   <= r_avg;
            r_o_level <= r_sat ? LEVEL_MAX : (r_zero ? '0 : r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_channel = r_o_ch;
    assign o_average     = r_o_avg;
    assign o_level       = r_o_level;

endmodule

FILE: tb/tb_three_channel_moving_average_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_channel_moving_average_level
// Self-checking bench for the three-channel boxcar average and level block.
// A short table of requests covers channel 3, extreme readings and window
// wrap, with results typed in where they are obvious. Random phases follow,
// each with new full-scale settings, including zero and one. The bench keeps
// its own boxcar rings, sums and dividers to predict every result. Random
// stalls on both sides, one long output hold-off and a quiet final phase set
// the timing.
// ----------------------------------------------------------------------------
module tb_three_channel_moving_average_level
    import tcmal_pkg::*;
();

    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 24;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_REPORTS      = 10;
    localparam int ITEMS_PER_PHASE  = 115;
    localparam int NUM_PHASES       = 6;
    localparam int NUM_DIRECTED     = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_RED_FS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GREEN_FS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLUE_FS  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE     = 2'd3;

    typedef struct packed {
        logic [CHAN_BITS-1:0]    channel;
        logic [READING_BITS-1:0] average;
        logic [LEVEL_BITS-1:0]   level;
    } t_level_result;

    typedef struct packed {
        logic [CHAN_BITS-1:0]    channel;
        logic [READING_BITS-1:0] reading;
        logic                    typed;
        logic [READING_BITS-1:0] average;
        logic [LEVEL_BITS-1:0]   level;
    } t_directed_row;

    typedef struct packed {
        logic [0:NUM_CHANNELS-1][FS_BITS-1:0] full_scale;
        logic                                 random_fs;
        logic [7:0]                           gap_pct;
        logic [7:0]                           stall_pct;
        logic                                 long_hold;
    } t_phase;

    // Full scale is 6062 here; the ring position only moves on blue requests.
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{CH_RED,    16'd0,     1'b1, 16'd0,     8'd0},
        '{CH_GREEN,  16'd0,     1'b1, 16'd0,     8'd0},
        '{CH_UNUSED, 16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_UNUSED, 16'd0,     1'b0, 16'd0,     8'd0},
        '{CH_RED,    16'd65535, 1'b1, 16'd8191,  8'd255},
        '{CH_GREEN,  16'd8,     1'b1, 16'd1,     8'd0},
        '{CH_BLUE,   16'd65535, 1'b1, 16'd8191,  8'd255},
        '{CH_RED,    16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_BLUE,   16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_RED,    16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_BLUE,   16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_RED,    16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_BLUE,   16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_RED,    16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_BLUE,   16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_RED,    16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_BLUE,   16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_RED,    16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_BLUE,   16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_RED,    16'd65535, 1'b1, 16'd65535, 8'd255},
        '{CH_BLUE,   16'd65535, 1'b1, 16'd65535, 8'd255},
        '{CH_RED,    16'd0,     1'b0, 16'd0,     8'd0},
        '{CH_GREEN,  16'd65535, 1'b0, 16'd0,     8'd0},
        '{CH_BLUE,   16'd1,     1'b0, 16'd0,     8'd0}
    };

    localparam t_phase PHASES [NUM_PHASES] = '{
        '{'{16'd1000, 16'd20000, 16'd65535}, 1'b0, 8'd20, 8'd20, 1'b0},
        '{'{16'd65535, 16'd65535, 16'd65535}, 1'b0, 8'd0, 8'd10, 1'b1},
        '{'{16'd1, 16'd1, 16'd1}, 1'b0, 8'd40, 8'd40, 1'b0},
        '{'{16'd0, 16'd0, 16'd0}, 1'b0, 8'd10, 8'd0, 1'b0},
        '{'{16'd0, 16'd0, 16'd0}, 1'b1, 8'd25, 8'd25, 1'b0},
        '{'{16'd300, 16'd6062, 16'd40000}, 1'b0, 8'd0, 8'd0, 1'b0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [CHAN_BITS-1:0]    i_channel;
    logic [READING_BITS-1:0] i_reading;
    logic                    o_valid;
    logic                    i_stall;
    logic [CHAN_BITS-1:0]    o_out_channel;
    logic [READING_BITS-1:0] o_average;
    logic [LEVEL_BITS-1:0]   o_level;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [FS_BITS-1:0]      i_cfg_data;

    logic                    req_typed         = 1'b0;
    logic [READING_BITS-1:0] req_typed_average = '0;
    logic [LEVEL_BITS-1:0]   req_typed_level   = '0;

    logic [READING_BITS-1:0] ring_model [NUM_CHANNELS][WINDOW];
    logic [SUM_BITS-1:0]     sum_model [NUM_CHANNELS];
    logic [POS_BITS-1:0]     pos_model;
    logic [FS_BITS-1:0]      full_scale_model [NUM_CHANNELS];
    t_level_result           pending_results [$];

    logic [FS_BITS-1:0]      phase_fs [NUM_CHANNELS];
    logic [CHAN_BITS-1:0]    next_rr_channel  = CH_RED;
    int                      source_gap_pct   = 15;
    int                      sink_stall_pct   = 15;
    logic                    hold_results_req = 1'b0;
    int                      failures         = 0;
    int                      idle_cycles      = 0;

    three_channel_moving_average_level i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_channel    (i_channel),
        .i_reading    (i_reading),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_channel(o_out_channel),
        .o_average    (o_average),
        .o_level      (o_level),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endfunction

    function automatic t_level_result predict_average_level(
        input logic [CHAN_BITS-1:0]    ch,
        input logic [READING_BITS-1:0] rd
    );
        t_level_result       res;
        logic [SUM_BITS-1:0] avg_wide;
        logic [31:0]         product;
        logic [FS_BITS-1:0]  fs;
        sum_model[ch] = sum_model[ch] - SUM_BITS'(ring_model[ch][pos_model]) + SUM_BITS'(rd);
        ring_model[ch][pos_model] = rd;
        if (ch == CH_BLUE) begin
            pos_model = (pos_model == POS_BITS'(WINDOW - 1)) ? '0 : pos_model + 1'b1;
        end
        avg_wide = sum_model[ch] >> WIN_SHIFT;
        fs = full_scale_model[ch];
        res.channel = ch;
        res.average = (avg_wide > SUM_BITS'(16'hFFFF)) ? '1 : avg_wide[READING_BITS-1:0];
        if (fs == '0) begin
            res.level = (res.average != '0) ? LEVEL_MAX : '0;
        end else if (res.average > fs) begin
            res.level = LEVEL_MAX;
        end else begin
            product = 32'(res.average) * 32'd255;
            res.level = LEVEL_BITS'(product / 32'(fs));
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_level_result expected;
        t_level_result actual;
        int c;
        int k;
        if (!i_rst_n) begin
            for (c = 0; c < NUM_CHANNELS; c++) begin
                for (k = 0; k < WINDOW; k++) begin
                    ring_model[c][k] = '0;
                end
                sum_model[c] = '0;
                full_scale_model[c] = FULL_SCALE_RESET;
            end
            pos_model = '0;
        end else begin
            if (i_cfg_we && i_cfg_index != REG_NONE) begin
                full_scale_model[i_cfg_index] = i_cfg_data;
            end
            if (o_valid && !i_stall) begin
                actual = '{o_out_channel, o_average, o_level};
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result channel %0d average %0d level %0d",
                                           actual.channel, actual.average, actual.level));
                end else begin
                    expected = pending_results.pop_front();
                    if (actual.channel !== expected.channel ||
                        actual.average !== expected.average ||
                        actual.level !== expected.level) begin
                        note_failure($sformatf(
                            "expected channel %0d average %0d level %0d, got %0d %0d %0d",
                            expected.channel, expected.average, expected.level,
                            actual.channel, actual.average, actual.level));
                    end
                end
            end
            if (i_valid && !o_stall && i_channel != CH_UNUSED) begin
                expected = predict_average_level(i_channel, i_reading);
                if (req_typed) begin
                    expected.average = req_typed_average;
                    expected.level = req_typed_level;
                end
                pending_results.push_back(expected);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : result_sink
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_results_req = 1'b0;
                i_stall <= 1'b0;
            end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(
        input logic [CHAN_BITS-1:0]    ch,
        input logic [READING_BITS-1:0] rd,
        input logic                    typed,
        input logic [READING_BITS-1:0] typed_average,
        input logic [LEVEL_BITS-1:0]   typed_level
    );
        i_valid <= 1'b1;
        i_channel <= ch;
        i_reading <= rd;
        req_typed <= typed;
        req_typed_average <= typed_average;
        req_typed_level <= typed_level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (source_gap_pct != 0 && $urandom_range(0, 99) < source_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_BITS-1:0] index,
        input logic [FS_BITS-1:0]      data
    );
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    initial begin : request_source
        int                      r;
        int                      p;
        int                      c;
        int                      n_sent;
        int                      near;
        logic [CHAN_BITS-1:0]    ch;
        logic [READING_BITS-1:0] rd;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_channel = CH_RED;
        i_reading = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_RED_FS;
        i_cfg_data = '0;
        for (c = 0; c < NUM_CHANNELS; c++) begin
            phase_fs[c] = FULL_SCALE_RESET;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_DIRECTED; r++) begin
            maybe_gap();
            send_request(DIRECTED_ROWS[r].channel, DIRECTED_ROWS[r].reading,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].average,
                         DIRECTED_ROWS[r].level);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_for_results();
            source_gap_pct = PHASES[p].gap_pct;
            sink_stall_pct = PHASES[p].stall_pct;
            for (c = 0; c < NUM_CHANNELS; c++) begin
                phase_fs[c] = PHASES[p].random_fs ? FS_BITS'($urandom_range(1, 65535))
                                                  : PHASES[p].full_scale[c];
            end
            write_register(REG_RED_FS, phase_fs[CH_RED]);
            write_register(REG_GREEN_FS, phase_fs[CH_GREEN]);
            write_register(REG_BLUE_FS, phase_fs[CH_BLUE]);
            write_register(REG_NONE, FS_BITS'($urandom));
            i_cfg_we <= 1'b0;
            if (PHASES[p].long_hold) begin
                hold_results_req = 1'b1;
            end

            n_sent = 0;
            while (n_sent < ITEMS_PER_PHASE) begin
                // Mostly red, green, blue in turn so the shared ring position advances.
                if ($urandom_range(0, 9) != 0) begin
                    ch = next_rr_channel;
                    next_rr_channel = (next_rr_channel == CH_BLUE) ? CH_RED
                                                                   : next_rr_channel + 1'b1;
                end else begin
                    ch = CHAN_BITS'($urandom_range(0, 3));
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        rd = READING_BITS'($urandom_range(0, 65535));
                    end
                    4, 5, 6, 7: begin
                        near = (ch == CH_UNUSED) ? 0 : int'(phase_fs[ch]);
                        near = near + int'($urandom_range(0, 16)) - 8;
                        rd = (near < 0) ? '0 : (near > 65535) ? '1 : READING_BITS'(near);
                    end
                    8: begin
                        rd = $urandom_range(0, 1) ? '1 : '0;
                    end
                    default: begin
                        rd = READING_BITS'($urandom_range(0, 31));
                    end
                endcase
                maybe_gap();
                send_request(ch, rd, 1'b0, '0, '0);
                if (ch != CH_UNUSED) begin
                    n_sent++;
                end
            end
        end

        wait_for_results();
        if (failures == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
